[src/lpr_pkg.sv]
// Shared constants and types for the LRU page replacement unit.
package lpr_pkg;

    localparam int MAX_FRAMES_DEF = 8;
    localparam int PAGE_BITS_DEF  = 8;

    localparam int PAGE_W      = 8;
    localparam int FRAME_IDX_W = 3;
    localparam int TOTAL_W     = 16;
    localparam int CFG_W       = 4;

    localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = CFG_W'(3);

    typedef struct packed {
        logic go;
        logic fill;
        logic evict;
    } t_cell_cmd;

endpackage

[src/lpr_intf.sv]
// Valid/ready channel interfaces for page references and replacement results.
interface lpr_ref_if;
    import lpr_pkg::*;

    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink (input valid, input page_number, output ready);
endinterface

interface lpr_res_if;
    import lpr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   page_fault;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic [TOTAL_W-1:0]     total_references;
    logic [TOTAL_W-1:0]     total_faults;

    modport source (output valid, output page_fault, output frame_index,
                    output total_references, output total_faults, input ready);
    modport sink (input valid, input page_fault, input frame_index,
                  input total_references, input total_faults, output ready);
endinterface

[src/lpr_cell.sv]
// One recency slot: holds a frame number and its page, ordered least recent first.
module lpr_cell #(
    parameter int POS       = 0,
    parameter int FRAME_W   = 3,
    parameter int PAGE_BITS = 8,
    parameter int CNT_W     = 4
) (
    input  logic                 i_clk,
    input  lpr_pkg::t_cell_cmd   i_cmd,
    input  logic [CNT_W-1:0]     i_filled,
    input  logic [CNT_W-1:0]     i_tail,
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic [FRAME_W-1:0]   i_fill_frame,
    input  logic [FRAME_W-1:0]   i_above_frame,
    input  logic [PAGE_BITS-1:0] i_above_page,
    input  logic                 i_pass,
    input  logic [FRAME_W-1:0]   i_carry_frame,
    output logic                 o_pass,
    output logic [FRAME_W-1:0]   o_carry_frame,
    output logic [FRAME_W-1:0]   o_frame,
    output logic [PAGE_BITS-1:0] o_page,
    output logic                 o_match
);
    import lpr_pkg::*;

    localparam logic [CNT_W-1:0] POS_C = CNT_W'(POS);

    logic [FRAME_W-1:0]   r_frame;
    logic [PAGE_BITS-1:0] r_page;
    logic                 removed;

    assign o_match = (POS_C < i_filled) && (r_page == i_page);

    // The slot leaving the order is the hit slot, or the oldest one on eviction.
    assign removed       = o_match || (i_cmd.evict && (POS == 0));
    assign o_pass        = i_pass || removed;
    assign o_carry_frame = i_pass ? i_carry_frame : r_frame;
    assign o_frame       = r_frame;
    assign o_page        = r_page;

    always_ff @(posedge i_clk) begin
        if (i_cmd.go) begin
            if (POS_C == i_tail) begin
                r_frame <= i_cmd.fill ? i_fill_frame : o_carry_frame;
                r_page  <= i_page;
            end else if (o_pass && (POS_C < i_tail)) begin
                r_frame <= i_above_frame;
                r_page  <= i_above_page;
            end
        end
    end

endmodule

[src/lru_page_replacement_unit.sv]
// LRU page replacement unit: a chain of recency slots plus fault and reference totals.
//
//   channel  | direction | payload
//   i_ref    | in        | page_number
//   o_res    | out       | page_fault, frame_index, total_references, total_faults
//   i_cfg_*  | in        | frames_in_use (write only)
//
// One reference is taken per cycle; its result is registered into the output
// register. The per-cycle work is the compare and one-slot shift along the chain
// of MAX_FRAMES slots. Reset empties the chain, clears both totals and sets the
// frame limit to 3. A stalled result holds the input off until it is taken.
module lru_page_replacement_unit #(
    parameter int MAX_FRAMES = lpr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = lpr_pkg::PAGE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lpr_pkg::CFG_W-1:0] i_cfg_data,
    lpr_ref_if.sink                   i_ref,
    lpr_res_if.source                 o_res
);
    import lpr_pkg::*;

    localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
    localparam int LIM_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_FRAMES);

    logic [CFG_W-1:0]   r_frames_in_use;
    logic [CNT_W-1:0]   r_filled;
    logic [CNT_W-1:0]   n_filled;
    logic [TOTAL_W-1:0] r_refs;
    logic [TOTAL_W-1:0] r_faults;

    logic                   r_out_valid;
    logic                   r_out_fault;
    logic [FRAME_IDX_W-1:0] r_out_frame;

    logic [LIM_W-1:0]     cfg_ext;
    logic [LIM_W-1:0]     limit;
    logic                 go;
    logic                 hit;
    logic                 has_room;
    logic [PAGE_BITS-1:0] page;
    logic [CNT_W-1:0]     tail;
    logic [FRAME_W-1:0]   fill_frame;
    logic [FRAME_W-1:0]   out_frame;
    t_cell_cmd            cmd;

    logic [MAX_FRAMES-1:0] match_vec;
    logic                  pass_chain  [MAX_FRAMES+1];
    logic [FRAME_W-1:0]    carry_chain [MAX_FRAMES+1];
    logic [FRAME_W-1:0]    slot_frame  [MAX_FRAMES+1];
    logic [PAGE_BITS-1:0]  slot_page   [MAX_FRAMES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= CFG_FRAMES_RESET;
        end else if (i_cfg_we) begin
            r_frames_in_use <= i_cfg_data;
        end
    end

    // Zero acts as one frame; anything above the chain length acts as the full chain.
    always_comb begin
        cfg_ext = LIM_W'(r_frames_in_use);
        if (cfg_ext == '0) begin
            limit = LIM_W'(1);
        end else if (cfg_ext > MAX_LIM) begin
            limit = MAX_LIM;
        end else begin
            limit = cfg_ext;
        end
    end

    assign page        = PAGE_BITS'(i_ref.page_number);
    assign i_ref.ready = !r_out_valid || o_res.ready;
    assign go          = i_ref.valid && i_ref.ready;
    assign hit         = |match_vec;
    assign has_room    = LIM_W'(r_filled) < limit;
    assign fill_frame  = FRAME_W'(r_filled);

    always_comb begin
        cmd.go    = go;
        cmd.fill  = !hit && has_room;
        cmd.evict = !hit && !has_room;
        tail      = cmd.fill ? r_filled : r_filled - CNT_W'(1);
        n_filled  = (go && cmd.fill) ? r_filled + CNT_W'(1) : r_filled;
    end

    assign pass_chain[0]           = 1'b0;
    assign carry_chain[0]          = '0;
    assign slot_frame[MAX_FRAMES]  = '0;
    assign slot_page[MAX_FRAMES]   = '0;

    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_slot
        lpr_cell #(
            .POS       (g),
            .FRAME_W   (FRAME_W),
            .PAGE_BITS (PAGE_BITS),
            .CNT_W     (CNT_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (cmd),
            .i_filled      (r_filled),
            .i_tail        (tail),
            .i_page        (page),
            .i_fill_frame  (fill_frame),
            .i_above_frame (slot_frame[g+1]),
            .i_above_page  (slot_page[g+1]),
            .i_pass        (pass_chain[g]),
            .i_carry_frame (carry_chain[g]),
            .o_pass        (pass_chain[g+1]),
            .o_carry_frame (carry_chain[g+1]),
            .o_frame       (slot_frame[g]),
            .o_page        (slot_page[g]),
            .o_match       (match_vec[g])
        );
    end

    // On a hit or an eviction the chain carries out the frame that was taken.
    assign out_frame = cmd.fill ? fill_frame : carry_chain[MAX_FRAMES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled    <= '0;
            r_refs      <= '0;
            r_faults    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_filled <= n_filled;
            if (go) begin
                r_out_valid <= 1'b1;
                if (r_refs != '1) begin
                    r_refs <= r_refs + TOTAL_W'(1);
                end
                if (!hit && (r_faults != '1)) begin
                    r_faults <= r_faults + TOTAL_W'(1);
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out_fault <= !hit;
            r_out_frame <= FRAME_IDX_W'(out_frame);
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.page_fault       = r_out_fault;
    assign o_res.frame_index      = r_out_frame;
    assign o_res.total_references = r_refs;
    assign o_res.total_faults     = r_faults;

endmodule
